// ===== design/sfcd_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the sync frame deframer.
package sfcd_pkg;

    localparam int COUNTER_WIDTH = 64;
    localparam int TOTAL_WIDTH   = 64;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
    localparam logic [31:0] SEQ_NONE     = 32'hFFFFFFFF;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;

    localparam logic [8:0] HDR_BYTES    = 9'd7;
    localparam logic [8:0] SEQ_LAST_POS = 9'd6;
    localparam logic [8:0] CRC_TAIL     = 9'd3;

    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef logic [COUNTER_WIDTH-1:0] cnt_t;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_HEAD  = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    typedef struct packed {
        logic        hdr_done;
        logic        payload;
        logic        status;
        logic        good;
        logic [31:0] seq;
        logic [7:0]  length;
        logic [7:0]  data;
    } parse_evt_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/sync_frame_crc32_deframer_core.sv =====
// Top level of the sync word framed packet deframer with CRC-32 check.
//
// The input channel (s_valid, s_ready, s_rx_byte) carries one received byte
// per transaction. The result channel (m_valid, m_ready, m_*) carries either
// a payload byte (m_kind low) or one end-of-frame status (m_kind high) that
// gives the CRC verdict, sequence number, length and the running totals.
// Payload bytes leave before the verdict; a receiver drops them on a bad
// status. Bytes outside a frame, header bytes and the first three CRC bytes
// produce no result.
// One byte per cycle is sustained while the receiver keeps m_ready high. A
// result appears on the output register the cycle after its byte is taken.
// The output register is a single stage: while the receiver holds m_ready
// low with a result waiting, s_ready falls and no byte is taken.
// The sync bytes are written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the block is idle; the block itself does not enforce it.
// A synchronous low aresetn returns the parser to the sync hunt, restores
// the default sync bytes, clears both totals, forgets the previous sequence
// and empties the output register.
module sync_frame_crc32_deframer_core
    import sfcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_kind,
    output logic [7:0]             m_data_byte,
    output logic                   m_frame_good,
    output logic [31:0]            m_sequence_res,
    output logic [7:0]             m_payload_length,
    output logic [TOTAL_WIDTH-1:0] m_total_expected,
    output logic [TOTAL_WIDTH-1:0] m_total_lost,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;

    logic       accept;
    parse_evt_t evt;
    cnt_t       expected_next;
    cnt_t       lost_next;

    logic                   valid_reg;
    logic                   kind_reg;
    logic [7:0]             data_reg;
    logic                   good_reg;
    logic [31:0]            seq_reg;
    logic [7:0]             len_reg;
    logic [TOTAL_WIDTH-1:0] exp_out_reg;
    logic [TOTAL_WIDTH-1:0] lost_out_reg;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    sfcd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_byte     (s_rx_byte),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .evt         (evt)
    );

    sfcd_stats u_stats (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .evt           (evt),
        .expected_next (expected_next),
        .lost_next     (lost_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (evt.payload || evt.status) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt.payload) begin
            kind_reg     <= KIND_PAYLOAD;
            data_reg     <= evt.data;
            good_reg     <= 1'b0;
            seq_reg      <= '0;
            len_reg      <= '0;
            exp_out_reg  <= '0;
            lost_out_reg <= '0;
        end else if (evt.status) begin
            kind_reg     <= KIND_STATUS;
            data_reg     <= '0;
            good_reg     <= evt.good;
            seq_reg      <= evt.seq;
            len_reg      <= evt.length;
            exp_out_reg  <= TOTAL_WIDTH'(expected_next);
            lost_out_reg <= TOTAL_WIDTH'(lost_next);
        end
    end

    assign m_valid          = valid_reg;
    assign m_kind           = kind_reg;
    assign m_data_byte      = data_reg;
    assign m_frame_good     = good_reg;
    assign m_sequence_res   = seq_reg;
    assign m_payload_length = len_reg;
    assign m_total_expected = exp_out_reg;
    assign m_total_lost     = lost_out_reg;

endmodule

// ===== design/sfcd_parser.sv =====
// Frame parser: sync hunt, header capture, payload pass-through and CRC check.
module sfcd_parser
    import sfcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic [7:0] sync_first,
    input  logic [7:0] sync_second,
    output parse_evt_t evt
);

    phase_t      phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcrc_reg, rcrc_next;

    logic [8:0]  body_limit;
    logic [31:0] crc_fold;
    logic [31:0] crc_start;
    logic [31:0] rcrc_shift;

    assign body_limit = HDR_BYTES + {1'b0, len_reg};
    assign crc_fold   = crc_byte(crc_reg, rx_byte);
    assign crc_start  = crc_byte(CRC_ALL_ONES, rx_byte);
    assign rcrc_shift = {rx_byte, rcrc_reg[31:8]};

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        seq_next   = seq_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT1: begin
                    if (rx_byte == sync_first) begin
                        crc_next   = crc_start;
                        pos_next   = 9'd1;
                        seq_next   = '0;
                        rcrc_next  = '0;
                        len_next   = '0;
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (rx_byte == sync_second) begin
                        crc_next   = crc_fold;
                        pos_next   = 9'd2;
                        phase_next = PH_HEAD;
                    end else if (rx_byte == sync_first) begin
                        crc_next   = crc_start;
                        pos_next   = 9'd1;
                        seq_next   = '0;
                        rcrc_next  = '0;
                        len_next   = '0;
                        phase_next = PH_HUNT2;
                    end else begin
                        pos_next   = '0;
                        phase_next = PH_HUNT1;
                    end
                end
                PH_HEAD: begin
                    crc_next = crc_fold;
                    pos_next = pos_reg + 9'd1;
                    if (pos_reg < SEQ_LAST_POS) begin
                        seq_next = {rx_byte, seq_reg[31:8]};
                    end else begin
                        len_next   = rx_byte;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (pos_reg < body_limit) begin
                        crc_next = crc_fold;
                        pos_next = pos_reg + 9'd1;
                    end else begin
                        rcrc_next = rcrc_shift;
                        if (pos_reg < body_limit + CRC_TAIL) begin
                            pos_next = pos_reg + 9'd1;
                        end else begin
                            pos_next   = '0;
                            crc_next   = CRC_ALL_ONES;
                            phase_next = PH_HUNT1;
                        end
                    end
                end
                default: phase_next = PH_HUNT1;
            endcase
        end
    end

    always_comb begin
        evt          = '0;
        evt.seq      = seq_reg;
        evt.length   = len_reg;
        evt.good     = (rcrc_shift == ~crc_reg);
        if (accept) begin
            unique case (phase_reg)
                PH_HEAD: begin
                    evt.hdr_done = (pos_reg == SEQ_LAST_POS);
                end
                PH_BODY: begin
                    if (pos_reg < body_limit) begin
                        evt.payload = 1'b1;
                        evt.data    = rx_byte;
                    end else if (!(pos_reg < body_limit + CRC_TAIL)) begin
                        evt.status = 1'b1;
                    end
                end
                default: evt.hdr_done = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT1;
            pos_reg   <= '0;
            len_reg   <= '0;
            seq_reg   <= '0;
            crc_reg   <= CRC_ALL_ONES;
            rcrc_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            seq_reg   <= seq_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
        end
    end

endmodule

// ===== design/sfcd_stats.sv =====
// Sequence gap tracking and the running expected and lost frame totals.
module sfcd_stats
    import sfcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  parse_evt_t evt,
    output cnt_t       expected_next,
    output cnt_t       lost_next
);

    logic [31:0] prev_reg, prev_next;
    cnt_t        exp_reg;
    cnt_t        lost_reg;
    logic [31:0] gap_reg;
    logic [31:0] gapp1_reg;

    logic        gap_counts;
    logic [31:0] seq_diff;
    logic [31:0] seq_gap;
    logic [63:0] gap_wide;
    logic [63:0] gapp1_wide;

    // The gap is settled once the header is in, ahead of the CRC bytes.
    assign gap_counts = (prev_reg != SEQ_NONE) && (evt.seq > prev_reg);
    assign seq_diff   = evt.seq - prev_reg;
    assign seq_gap    = evt.seq + ~prev_reg;
    assign gap_wide   = {32'd0, gap_reg};
    assign gapp1_wide = {32'd0, gapp1_reg};

    always_comb begin
        expected_next = exp_reg;
        lost_next     = lost_reg;
        prev_next     = prev_reg;
        if (evt.status) begin
            if (evt.good) begin
                expected_next = exp_reg + gapp1_wide[COUNTER_WIDTH-1:0];
                lost_next     = lost_reg + gap_wide[COUNTER_WIDTH-1:0];
                prev_next     = evt.seq;
            end else begin
                expected_next = exp_reg + cnt_t'(1);
                lost_next     = lost_reg + cnt_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= SEQ_NONE;
            exp_reg  <= '0;
            lost_reg <= '0;
        end else begin
            prev_reg <= prev_next;
            exp_reg  <= expected_next;
            lost_reg <= lost_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt.hdr_done) begin
            gap_reg   <= gap_counts ? seq_gap : 32'd0;
            gapp1_reg <= gap_counts ? seq_diff : 32'd1;
        end
    end

endmodule

// ===== design/sfcd_checker.sv =====
// Port-level checker for the deframer core and its bind to the top level.
module sfcd_checker
    import sfcd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_kind,
    input logic [7:0]             m_data_byte,
    input logic                   m_frame_good,
    input logic [31:0]            m_sequence_res,
    input logic [7:0]             m_payload_length,
    input logic [TOTAL_WIDTH-1:0] m_total_expected,
    input logic [TOTAL_WIDTH-1:0] m_total_lost
);

    // An empty output register always leaves room for a new byte.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with an empty output register");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_PAYLOAD) |->
            !m_frame_good && (m_sequence_res == '0) && (m_payload_length == '0) &&
            (m_total_expected == '0) && (m_total_lost == '0))
        else $error("payload transaction carries status fields");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_STATUS) |-> (m_data_byte == '0))
        else $error("status transaction carries a data byte");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_data_byte) &&
            $stable(m_total_expected) && $stable(m_total_lost))
        else $error("stalled result changed");

endmodule

bind sync_frame_crc32_deframer_core sfcd_checker u_sfcd_checker (.*);
